>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, held off during reset
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication on clk, held off during reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/pfpe_pkg.sv
package pfpe_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  localparam int OP_W      = 3;
  localparam int COL_IN_W  = 7;
  localparam int ROW_IN_W  = 6;
  localparam int ROW_BIT_W = 3;
  localparam int DATA_W    = 8;
  localparam int COL_OUT_W = 7;
  localparam int PG_OUT_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOCATE = 3'd0,
    OP_WRITE  = 3'd1,
    OP_READ   = 3'd2,
    OP_PSET   = 3'd3,
    OP_FILL   = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    AS_CURSOR,
    AS_LOCATE,
    AS_SWEEP
  } addr_sel_t;

  typedef enum logic [1:0] {
    WD_DATA,
    WD_PIXEL,
    WD_FILL,
    WD_ZERO
  } wdata_sel_t;

  typedef struct packed {
    logic       capture;
    logic       cur_locate;
    logic       cur_advance;
    logic       cur_fill_end;
    logic       mem_we;
    logic       mem_re;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       load_result;
    logic       result_rd;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sweep_last;
  } status_t;

endpackage

>>> design/pfpe_ctrl.sv
module pfpe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pfpe_pkg::status_t status,
  output pfpe_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_FILL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.addr_sel  = pfpe_pkg::AS_CURSOR;
    cmd.wdata_sel = pfpe_pkg::WD_DATA;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = pfpe_pkg::AS_SWEEP;
        cmd.wdata_sel = pfpe_pkg::WD_ZERO;
        cmd.sweep_inc = 1'b1;
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status.op)
          pfpe_pkg::OP_LOCATE: begin
            cmd.cur_locate  = 1'b1;
            cmd.load_result = 1'b1;
            state_nxt       = ST_IDLE;
          end
          pfpe_pkg::OP_WRITE: begin
            cmd.mem_we      = 1'b1;
            cmd.wdata_sel   = pfpe_pkg::WD_DATA;
            cmd.cur_advance = 1'b1;
            cmd.load_result = 1'b1;
            state_nxt       = ST_IDLE;
          end
          pfpe_pkg::OP_READ: begin
            cmd.mem_re = 1'b1;
            state_nxt  = ST_FETCH;
          end
          pfpe_pkg::OP_PSET: begin
            cmd.cur_locate = 1'b1;
            cmd.mem_re     = 1'b1;
            cmd.addr_sel   = pfpe_pkg::AS_LOCATE;
            state_nxt      = ST_FETCH;
          end
          pfpe_pkg::OP_FILL: begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = ST_FILL;
          end
          default: begin
            cmd.load_result = 1'b1;
            state_nxt       = ST_IDLE;
          end
        endcase
      end
      ST_FETCH: begin
        if (status.op == pfpe_pkg::OP_PSET) begin
          cmd.mem_we      = 1'b1;
          cmd.wdata_sel   = pfpe_pkg::WD_PIXEL;
          cmd.cur_advance = 1'b1;
        end else begin
          cmd.result_rd = 1'b1;
        end
        cmd.load_result = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_FILL: begin
        cmd.mem_we    = 1'b1;
        cmd.addr_sel  = pfpe_pkg::AS_SWEEP;
        cmd.wdata_sel = pfpe_pkg::WD_FILL;
        cmd.sweep_inc = 1'b1;
        if (status.sweep_last) begin
          cmd.cur_fill_end = 1'b1;
          cmd.load_result  = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/pfpe_datapath.sv
module pfpe_datapath #(
  parameter int COLUMNS = pfpe_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfpe_pkg::PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfpe_pkg::cmd_t                  cmd,
  input  logic [pfpe_pkg::OP_W-1:0]       in_op,
  input  logic [pfpe_pkg::COL_IN_W-1:0]   in_column,
  input  logic [pfpe_pkg::ROW_IN_W-1:0]   in_row,
  input  logic [pfpe_pkg::DATA_W-1:0]     in_data,
  input  logic                            in_color,
  output pfpe_pkg::status_t               status,
  output logic [pfpe_pkg::DATA_W-1:0]     out_read_data,
  output logic [pfpe_pkg::COL_OUT_W-1:0]  out_cursor_col,
  output logic [pfpe_pkg::PG_OUT_W-1:0]   out_cursor_pg
);

  localparam int CW       = $clog2(COLUMNS);
  localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int DEPTH    = COLUMNS * PAGES;
  localparam int AW       = $clog2(DEPTH);
  localparam int COL_TBLN = 2 ** pfpe_pkg::COL_IN_W;
  localparam int PG_IN_W  = pfpe_pkg::ROW_IN_W - pfpe_pkg::ROW_BIT_W;
  localparam int PG_TBLN  = 2 ** PG_IN_W;
  localparam logic [AW-1:0] COL_STRIDE = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [PW-1:0] LAST_PG    = PW'(PAGES - 1);

  pfpe_pkg::op_t                  op_r;
  logic [pfpe_pkg::COL_IN_W-1:0]  col_r;
  logic [pfpe_pkg::ROW_IN_W-1:0]  row_r;
  logic [pfpe_pkg::DATA_W-1:0]    data_r;
  logic                           color_r;

  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [PW-1:0] cur_pg_r, cur_pg_nxt;
  logic [AW-1:0] sweep_r, sweep_nxt;

  logic [pfpe_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [pfpe_pkg::DATA_W-1:0] rd_data_r;
  logic [pfpe_pkg::DATA_W-1:0] mem_wdata;
  logic [pfpe_pkg::DATA_W-1:0] pix_mask;
  logic [pfpe_pkg::DATA_W-1:0] pix_byte;
  logic [AW-1:0]               mem_addr;

  logic [pfpe_pkg::DATA_W-1:0]   res_rd_r;
  logic [pfpe_pkg::COL_OUT_W-1:0] res_col_r;
  logic [pfpe_pkg::PG_OUT_W-1:0]  res_pg_r;

  logic [CW-1:0] col_tbl [COL_TBLN];
  logic [PW-1:0] pg_tbl  [PG_TBLN];
  logic [CW-1:0] loc_col;
  logic [PW-1:0] loc_pg;

  // column and page reduced modulo the memory size
  for (genvar gi = 0; gi < COL_TBLN; gi++) begin : g_col_tbl
    localparam int CV = gi % COLUMNS;
    assign col_tbl[gi] = CW'(CV);
  end
  for (genvar gp = 0; gp < PG_TBLN; gp++) begin : g_pg_tbl
    localparam int PV = gp % PAGES;
    assign pg_tbl[gp] = PW'(PV);
  end

  assign loc_col = col_tbl[col_r];
  assign loc_pg  = pg_tbl[row_r[pfpe_pkg::ROW_IN_W-1:pfpe_pkg::ROW_BIT_W]];

  assign status.op         = op_r;
  assign status.sweep_last = (sweep_r == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= pfpe_pkg::op_t'(in_op);
      col_r   <= in_column;
      row_r   <= in_row;
      data_r  <= in_data;
      color_r <= in_color;
    end
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_pg_nxt  = cur_pg_r;
    if (cmd.cur_locate) begin
      cur_col_nxt = loc_col;
      cur_pg_nxt  = loc_pg;
    end else if (cmd.cur_advance) begin
      cur_col_nxt = (cur_col_r == LAST_COL) ? '0 : cur_col_r + CW'(1);
    end else if (cmd.cur_fill_end) begin
      cur_col_nxt = '0;
      cur_pg_nxt  = LAST_PG;
    end
  end

  always_comb begin
    if (cmd.sweep_clr) begin
      sweep_nxt = '0;
    end else if (cmd.sweep_inc) begin
      sweep_nxt = sweep_r + AW'(1);
    end else begin
      sweep_nxt = sweep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_pg_r  <= '0;
      sweep_r   <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_pg_r  <= cur_pg_nxt;
      sweep_r   <= sweep_nxt;
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      pfpe_pkg::AS_CURSOR: mem_addr = AW'(cur_pg_r) * COL_STRIDE + AW'(cur_col_r);
      pfpe_pkg::AS_LOCATE: mem_addr = AW'(loc_pg) * COL_STRIDE + AW'(loc_col);
      pfpe_pkg::AS_SWEEP:  mem_addr = sweep_r;
      default:             mem_addr = sweep_r;
    endcase
  end

  assign pix_mask = pfpe_pkg::DATA_W'(1) << row_r[pfpe_pkg::ROW_BIT_W-1:0];
  assign pix_byte = color_r ? (rd_data_r | pix_mask) : (rd_data_r & ~pix_mask);

  always_comb begin
    unique case (cmd.wdata_sel)
      pfpe_pkg::WD_DATA:  mem_wdata = data_r;
      pfpe_pkg::WD_PIXEL: mem_wdata = pix_byte;
      pfpe_pkg::WD_FILL:  mem_wdata = data_r;
      pfpe_pkg::WD_ZERO:  mem_wdata = '0;
      default:            mem_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_re) begin
      rd_data_r <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_rd_r  <= cmd.result_rd ? rd_data_r : '0;
      res_col_r <= pfpe_pkg::COL_OUT_W'(cur_col_nxt);
      res_pg_r  <= pfpe_pkg::PG_OUT_W'(cur_pg_nxt);
    end
  end

  assign out_read_data  = res_rd_r;
  assign out_cursor_col = res_col_r;
  assign out_cursor_pg  = res_pg_r;

endmodule

>>> design/page_framebuffer_pixel_engine_core.sv
// page-organized monochrome display memory of COLUMNS x PAGES bytes, one
// result item per input item. the memory is one single-port synchronous ram,
// so timing is set by its port: locate, write byte and unused codes load
// their result in the execute state, read byte reads the ram and loads it
// in the fetch state, set pixel reads the byte and writes it back, and fill
// writes every byte of the memory, one byte a cycle. the output holds one
// result item; while it waits under out_stall, in_stall stays high, and a
// new item can be accepted at the same edge at which the waiting result is
// taken. after reset the block clears every byte with in_stall held high.
`include "assert_macros.svh"

module page_framebuffer_pixel_engine_core #(
  parameter int COLUMNS = pfpe_pkg::COLUMNS_DEF,
  parameter int PAGES   = pfpe_pkg::PAGES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pfpe_pkg::OP_W-1:0]       in_op,
  input  logic [pfpe_pkg::COL_IN_W-1:0]   in_column,
  input  logic [pfpe_pkg::ROW_IN_W-1:0]   in_row,
  input  logic [pfpe_pkg::DATA_W-1:0]     in_data,
  input  logic                            in_color,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfpe_pkg::DATA_W-1:0]     out_read_data,
  output logic [pfpe_pkg::COL_OUT_W-1:0]  out_cursor_col,
  output logic [pfpe_pkg::PG_OUT_W-1:0]   out_cursor_pg
);

  pfpe_pkg::cmd_t    cmd;
  pfpe_pkg::status_t status;

  pfpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pfpe_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_op          (in_op),
    .in_column      (in_column),
    .in_row         (in_row),
    .in_data        (in_data),
    .in_color       (in_color),
    .status         (status),
    .out_read_data  (out_read_data),
    .out_cursor_col (out_cursor_col),
    .out_cursor_pg  (out_cursor_pg)
  );

  // an accepted item blocks the input until its result is loaded
  `AST_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)
  // a result is only loaded into an empty output slot
  `AST_IMPL(a_load_into_free_slot, cmd.load_result, !out_valid)
  // single-port ram never reads and writes in the same cycle
  `AST_IMPL(a_one_port_access, cmd.mem_we, !cmd.mem_re)

endmodule
